// ----- design/assert_macros.svh -----
// Assertion shorthands used by umc_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UMC_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication.
`define UMC_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// ----- design/umc_pkg.sv -----
package umc_pkg;

  localparam logic [3:0] OP_CMOV     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_STORE    = 4'd2;
  localparam logic [3:0] OP_ADD      = 4'd3;
  localparam logic [3:0] OP_MUL      = 4'd4;
  localparam logic [3:0] OP_DIV      = 4'd5;
  localparam logic [3:0] OP_NAND     = 4'd6;
  localparam logic [3:0] OP_HALT     = 4'd7;
  localparam logic [3:0] OP_MAP      = 4'd8;
  localparam logic [3:0] OP_UNMAP    = 4'd9;
  localparam logic [3:0] OP_OUT      = 4'd10;
  localparam logic [3:0] OP_IN       = 4'd11;
  localparam logic [3:0] OP_LOADPROG = 4'd12;
  localparam logic [3:0] OP_IMM      = 4'd13;

  localparam logic [2:0] FLT_NONE    = 3'd0;
  localparam logic [2:0] FLT_DIVZERO = 3'd1;
  localparam logic [2:0] FLT_SEGMENT = 3'd2;
  localparam logic [2:0] FLT_OPCODE  = 3'd3;
  localparam logic [2:0] FLT_OUTPUT  = 3'd4;
  localparam logic [2:0] FLT_MAP     = 3'd5;
  localparam logic [2:0] FLT_UNMAP   = 3'd6;
  localparam logic [2:0] FLT_PC_END  = 3'd7;

  localparam logic REQ_APPEND = 1'b0;

  localparam logic [31:0] OUT_MAX = 32'd255;

  typedef enum logic [5:0] {
    CMD_NONE, CMD_APPEND, CMD_FETCH, CMD_HALT, CMD_DECODE, CMD_RD_C, CMD_RD_A,
    CMD_LATCH_A, CMD_WR_MOVE, CMD_WR_ADD, CMD_WR_NAND, CMD_WR_IMM, CMD_WR_INPUT,
    CMD_OUTPUT, CMD_MUL, CMD_WR_PROD, CMD_DIV_INIT, CMD_DIV_STEP, CMD_WR_QUO,
    CMD_LEN_A, CMD_LEN_B, CMD_MEM_LOAD, CMD_WR_LOAD, CMD_STORE, CMD_MAP_POP,
    CMD_MAP_TAKE, CMD_MAP_FRESH, CMD_CLEAR, CMD_MAP_DONE, CMD_UNMAP,
    CMD_COPY_INIT, CMD_COPY_RD, CMD_COPY_WR, CMD_JUMP_LEN, CMD_JUMP, CMD_PUBLISH
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t     op;
    logic       start;
    logic [2:0] cause;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic stopped;
    logic pc_end;
    logic vb_nz;
    logic vc_nz;
    logic sega_ok;
    logic segb_ok;
    logic segc_ok;
    logic map_big;
    logic free_any;
    logic fresh_any;
    logic free_full;
    logic out_big;
    logic off_b_ok;
    logic off_c_ok;
    logic cnt_zero;
    logic clr_more;
    logic copy_more;
    logic out_free;
  } status_t;

endpackage

// ----- design/umc_ctrl.sv -----
module umc_ctrl
  import umc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    opcode,
  input  status_t st,
  output logic    in_stall,
  output cmd_t    cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_FETCH  = 16'h0002,
    S_RB     = 16'h0004,
    S_RC     = 16'h0008,
    S_RA     = 16'h0010,
    S_EXEC   = 16'h0020,
    S_LEN    = 16'h0040,
    S_LOADWB = 16'h0080,
    S_MULWB  = 16'h0100,
    S_DIV    = 16'h0200,
    S_DIVWB  = 16'h0400,
    S_MAPID  = 16'h0800,
    S_CLEAR  = 16'h1000,
    S_COPY   = 16'h2000,
    S_COPYWR = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = CMD_NONE;
    cmd.start = 1'b0;
    cmd.cause = FLT_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_DONE;
          if (opcode == REQ_APPEND) begin
            cmd.op = CMD_APPEND;
          end else if (st.stopped) begin
            cmd.op = CMD_NONE;
          end else if (st.pc_end) begin
            cmd.op = CMD_HALT;
            cmd.cause = FLT_PC_END;
          end else begin
            cmd.op = CMD_FETCH;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.op = CMD_DECODE;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.op = CMD_RD_C;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.op = CMD_RD_A;
        state_next = S_RA;
      end
      S_RA: begin
        cmd.op = CMD_LATCH_A;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (st.op)
          OP_CMOV: cmd.op = st.vc_nz ? CMD_WR_MOVE : CMD_NONE;
          OP_LOAD: begin
            if (st.segb_ok) begin
              cmd.op = CMD_LEN_B;
              state_next = S_LEN;
            end else begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_SEGMENT;
            end
          end
          OP_STORE: begin
            if (st.sega_ok) begin
              cmd.op = CMD_LEN_A;
              state_next = S_LEN;
            end else begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_SEGMENT;
            end
          end
          OP_ADD:  cmd.op = CMD_WR_ADD;
          OP_MUL: begin
            cmd.op = CMD_MUL;
            state_next = S_MULWB;
          end
          OP_DIV: begin
            if (st.vc_nz) begin
              cmd.op = CMD_DIV_INIT;
              state_next = S_DIV;
            end else begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_DIVZERO;
            end
          end
          OP_NAND: cmd.op = CMD_WR_NAND;
          OP_HALT: begin
            cmd.op = CMD_HALT;
            cmd.cause = FLT_NONE;
          end
          OP_MAP: begin
            if (st.map_big) begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_MAP;
            end else if (st.free_any) begin
              cmd.op = CMD_MAP_POP;
              state_next = S_MAPID;
            end else if (st.fresh_any) begin
              cmd.op = CMD_MAP_FRESH;
              state_next = S_CLEAR;
            end else begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_MAP;
            end
          end
          OP_UNMAP: begin
            if (!st.vc_nz || !st.segc_ok || st.free_full) begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_UNMAP;
            end else begin
              cmd.op = CMD_UNMAP;
            end
          end
          OP_OUT: begin
            if (st.out_big) begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_OUTPUT;
            end else begin
              cmd.op = CMD_OUTPUT;
            end
          end
          OP_IN:  cmd.op = CMD_WR_INPUT;
          OP_LOADPROG: begin
            if (!st.vb_nz) begin
              cmd.op = CMD_JUMP;
            end else if (st.segb_ok) begin
              cmd.op = CMD_LEN_B;
              state_next = S_LEN;
            end else begin
              cmd.op = CMD_HALT;
              cmd.cause = FLT_SEGMENT;
            end
          end
          OP_IMM: cmd.op = CMD_WR_IMM;
          default: begin
            cmd.op = CMD_HALT;
            cmd.cause = FLT_OPCODE;
          end
        endcase
      end
      S_LEN: begin
        state_next = S_DONE;
        if (st.op == OP_LOADPROG) begin
          cmd.op = CMD_COPY_INIT;
          state_next = S_COPY;
        end else if (st.op == OP_LOAD) begin
          if (st.off_c_ok) begin
            cmd.op = CMD_MEM_LOAD;
            state_next = S_LOADWB;
          end else begin
            cmd.op = CMD_HALT;
            cmd.cause = FLT_SEGMENT;
          end
        end else if (st.off_b_ok) begin
          cmd.op = CMD_STORE;
        end else begin
          cmd.op = CMD_HALT;
          cmd.cause = FLT_SEGMENT;
        end
      end
      S_LOADWB: begin
        cmd.op = CMD_WR_LOAD;
        state_next = S_DONE;
      end
      S_MULWB: begin
        cmd.op = CMD_WR_PROD;
        state_next = S_DONE;
      end
      S_DIV: begin
        if (st.cnt_zero) begin
          state_next = S_DIVWB;
        end else begin
          cmd.op = CMD_DIV_STEP;
        end
      end
      S_DIVWB: begin
        cmd.op = CMD_WR_QUO;
        state_next = S_DONE;
      end
      S_MAPID: begin
        cmd.op = CMD_MAP_TAKE;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        if (st.clr_more) begin
          cmd.op = CMD_CLEAR;
        end else begin
          cmd.op = CMD_MAP_DONE;
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        if (st.copy_more) begin
          cmd.op = CMD_COPY_RD;
          state_next = S_COPYWR;
        end else begin
          cmd.op = CMD_JUMP_LEN;
          state_next = S_DONE;
        end
      end
      S_COPYWR: begin
        cmd.op = CMD_COPY_WR;
        state_next = S_COPY;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op = CMD_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/umc_dp.sv -----
`include "assert_macros.svh"

module umc_dp
  import umc_pkg::*;
#(
  parameter int SEG_COUNT = 16,
  parameter int SEG_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [31:0] program_word,
  input  logic [7:0]  in_byte,
  input  logic        in_end,
  input  logic        res_stall,
  output status_t     st,
  output logic        res_valid,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        input_taken,
  output logic        stopped,
  output logic [2:0]  fault_code
);

  localparam int SEG_W  = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
  localparam int OFF_W  = $clog2(SEG_WORDS);
  localparam int LEN_W  = $clog2(SEG_WORDS + 1);
  localparam int CNT_W  = (LEN_W > 6) ? LEN_W : 6;
  localparam int FC_W   = $clog2(SEG_COUNT + 1);
  localparam int ADDR_W = SEG_W + OFF_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;
  logic [31:0] rf [8];
  logic [7:0]  rfv;
  logic [31:0] rf_q;
  logic [LEN_W-1:0] lenram [SEG_COUNT];
  logic [SEG_W-1:0] fifo [SEG_COUNT];
  logic [SEG_W-1:0] fifo_q;

  logic [31:0] instr, va, vb, vc, pc, prod, rem, quo;
  logic [LEN_W-1:0] len0, len_q;
  logic [CNT_W-1:0] cnt;
  logic [SEG_W-1:0] id;
  logic [SEG_COUNT-1:0] mapped;
  logic [SEG_W-1:0] free_head, free_tail;
  logic [FC_W-1:0]  free_count, next_fresh;
  logic stop_flag;
  logic [2:0] stop_cause;
  logic [7:0] in_byte_q;
  logic in_end_q;
  logic stg_ov, stg_taken;
  logic [7:0] stg_ob;

  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;
  logic rf_we, rf_re;
  logic [2:0] rf_wa, rf_ra;
  logic [31:0] rf_wd;
  logic [32:0] div_sh;
  logic div_ge;

  assign div_sh = {rem, quo[31]};
  assign div_ge = div_sh >= {1'b0, vc};

  always_comb begin
    st.op        = instr[31:28];
    st.stopped   = stop_flag;
    st.pc_end    = pc >= 32'(len0);
    st.vb_nz     = vb != '0;
    st.vc_nz     = vc != '0;
    st.sega_ok   = (va < 32'(SEG_COUNT)) && mapped[va[SEG_W-1:0]];
    st.segb_ok   = (vb < 32'(SEG_COUNT)) && mapped[vb[SEG_W-1:0]];
    st.segc_ok   = (vc < 32'(SEG_COUNT)) && mapped[vc[SEG_W-1:0]];
    st.map_big   = vc > 32'(SEG_WORDS);
    st.free_any  = free_count != '0;
    st.fresh_any = next_fresh < FC_W'(SEG_COUNT);
    st.free_full = free_count >= FC_W'(SEG_COUNT);
    st.out_big   = vc > OUT_MAX;
    st.off_b_ok  = vb < 32'(len_q);
    st.off_c_ok  = vc < 32'(len_q);
    st.cnt_zero  = cnt == '0;
    st.clr_more  = 32'(cnt) < vc;
    st.copy_more = (LEN_W + CNT_W)'(cnt) < (LEN_W + CNT_W)'(len_q);
    st.out_free  = !res_valid || !res_stall;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    case (cmd.op)
      CMD_APPEND: begin
        mem_we = len0 < LEN_W'(SEG_WORDS);
        mem_wa = {SEG_W'(0), len0[OFF_W-1:0]};
        mem_wd = program_word;
      end
      CMD_STORE: begin
        mem_we = 1'b1;
        mem_wa = {va[SEG_W-1:0], vb[OFF_W-1:0]};
        mem_wd = vc;
      end
      CMD_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = {id, cnt[OFF_W-1:0]};
      end
      CMD_COPY_WR: begin
        mem_we = 1'b1;
        mem_wa = {SEG_W'(0), cnt[OFF_W-1:0]};
        mem_wd = mem_q;
      end
      CMD_FETCH: begin
        mem_re = 1'b1;
        mem_ra = {SEG_W'(0), pc[OFF_W-1:0]};
      end
      CMD_MEM_LOAD: begin
        mem_re = 1'b1;
        mem_ra = {vb[SEG_W-1:0], vc[OFF_W-1:0]};
      end
      CMD_COPY_RD: begin
        mem_re = 1'b1;
        mem_ra = {vb[SEG_W-1:0], cnt[OFF_W-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    rf_we = 1'b1;
    rf_wa = instr[8:6];
    rf_wd = '0;
    rf_re = 1'b1;
    rf_ra = instr[8:6];
    case (cmd.op)
      CMD_DECODE: rf_ra = mem_q[5:3];
      CMD_RD_C:   rf_ra = instr[2:0];
      default:    rf_re = cmd.op == CMD_RD_A;
    endcase
    case (cmd.op)
      CMD_WR_MOVE: rf_wd = vb;
      CMD_WR_ADD:  rf_wd = vb + vc;
      CMD_WR_NAND: rf_wd = ~(vb & vc);
      CMD_WR_PROD: rf_wd = prod;
      CMD_WR_QUO:  rf_wd = quo;
      CMD_WR_LOAD: rf_wd = mem_q;
      CMD_WR_IMM: begin
        rf_wa = instr[27:25];
        rf_wd = {7'b0, instr[24:0]};
      end
      CMD_WR_INPUT: begin
        rf_wa = instr[2:0];
        rf_wd = in_end_q ? '1 : {24'b0, in_byte_q};
      end
      CMD_MAP_DONE: begin
        rf_wa = instr[5:3];
        rf_wd = 32'(id);
      end
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_re) begin
      rf_q <= rfv[rf_ra] ? rf[rf_ra] : '0;
    end
    if (cmd.op == CMD_MAP_DONE) begin
      lenram[id] <= vc[LEN_W-1:0];
    end
    if (cmd.op == CMD_LEN_A) begin
      len_q <= (va[SEG_W-1:0] == '0) ? len0 : lenram[va[SEG_W-1:0]];
    end else if (cmd.op == CMD_LEN_B) begin
      len_q <= (vb[SEG_W-1:0] == '0) ? len0 : lenram[vb[SEG_W-1:0]];
    end
    if (cmd.op == CMD_UNMAP) begin
      fifo[free_tail] <= vc[SEG_W-1:0];
    end
    if (cmd.op == CMD_MAP_POP) begin
      fifo_q <= fifo[free_head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      in_byte_q <= in_byte;
      in_end_q  <= in_end;
    end
    case (cmd.op)
      CMD_DECODE:   instr <= mem_q;
      CMD_RD_C:     vb <= rf_q;
      CMD_RD_A:     vc <= rf_q;
      CMD_LATCH_A:  va <= rf_q;
      CMD_MUL:      prod <= vb * vc;
      CMD_DIV_INIT: begin
        rem <= '0;
        quo <= vb;
        cnt <= CNT_W'(32);
      end
      CMD_DIV_STEP: begin
        rem <= div_ge ? 32'(div_sh - {1'b0, vc}) : div_sh[31:0];
        quo <= {quo[30:0], div_ge};
        cnt <= cnt - 1'b1;
      end
      CMD_MAP_FRESH: begin
        id  <= next_fresh[SEG_W-1:0];
        cnt <= '0;
      end
      CMD_MAP_TAKE: begin
        id  <= fifo_q;
        cnt <= '0;
      end
      CMD_CLEAR, CMD_COPY_WR: cnt <= cnt + 1'b1;
      CMD_COPY_INIT: cnt <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rfv         <= '0;
      pc          <= '0;
      len0        <= '0;
      mapped      <= SEG_COUNT'(1);
      free_head   <= '0;
      free_tail   <= '0;
      free_count  <= '0;
      next_fresh  <= FC_W'(1);
      stop_flag   <= 1'b0;
      stop_cause  <= FLT_NONE;
      stg_ov      <= 1'b0;
      stg_ob      <= '0;
      stg_taken   <= 1'b0;
      res_valid   <= 1'b0;
      out_valid   <= 1'b0;
      out_byte    <= '0;
      input_taken <= 1'b0;
      stopped     <= 1'b0;
      fault_code  <= FLT_NONE;
    end else begin
      if (rf_we) begin
        rfv[rf_wa] <= 1'b1;
      end
      if (cmd.start) begin
        stg_ov    <= 1'b0;
        stg_ob    <= '0;
        stg_taken <= 1'b0;
      end
      case (cmd.op)
        CMD_APPEND: begin
          if (len0 < LEN_W'(SEG_WORDS)) begin
            len0 <= len0 + 1'b1;
          end
        end
        CMD_HALT: begin
          stop_flag  <= 1'b1;
          stop_cause <= cmd.cause;
        end
        CMD_DECODE: pc <= pc + 1'b1;
        CMD_OUTPUT: begin
          stg_ov <= 1'b1;
          stg_ob <= vc[7:0];
        end
        CMD_WR_INPUT: stg_taken <= !in_end_q;
        CMD_MAP_POP: begin
          free_head  <= (free_head == SEG_W'(SEG_COUNT - 1)) ? '0 : free_head + 1'b1;
          free_count <= free_count - 1'b1;
        end
        CMD_MAP_FRESH: next_fresh <= next_fresh + 1'b1;
        CMD_MAP_DONE:  mapped[id] <= 1'b1;
        CMD_UNMAP: begin
          mapped[vc[SEG_W-1:0]] <= 1'b0;
          free_tail  <= (free_tail == SEG_W'(SEG_COUNT - 1)) ? '0 : free_tail + 1'b1;
          free_count <= free_count + 1'b1;
        end
        CMD_JUMP_LEN: begin
          len0 <= len_q;
          pc   <= vc;
        end
        CMD_JUMP: pc <= vc;
        default: ;
      endcase
      if (cmd.op == CMD_PUBLISH) begin
        res_valid   <= 1'b1;
        out_valid   <= stg_ov;
        out_byte    <= stg_ob;
        input_taken <= stg_taken;
        stopped     <= stop_flag;
        fault_code  <= stop_cause;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `UMC_ASSERT_NEXT(a_stop_sticky, stop_flag, stop_flag)
  `UMC_ASSERT_NOW(a_free_bound, 1'b1, free_count <= FC_W'(SEG_COUNT))
  `UMC_ASSERT_NOW(a_len0_bound, 1'b1, len0 <= LEN_W'(SEG_WORDS))
  `UMC_ASSERT_NOW(a_no_mem_hazard, mem_we, !(cmd.op == CMD_HALT))

endmodule

// ----- design/segmented_um_core_top.sv -----
// An append request, or an execute request on a stopped machine, goes straight to publishing its result.
// An instruction steps through fetch, three register-file reads, execute and write-back.
// Divide runs one quotient bit a cycle; map pops a recycled segment id if one is free, then
// clears the new segment word by word; load program copies each word with a read and a write.
// One request at a time: in_stall stays high until the result is published, which res_stall can delay.
// Reset: synchronous, active high; registers zero, only segment zero mapped, no clearing pass.
module segmented_um_core_top
  import umc_pkg::*;
#(
  parameter int SEG_COUNT = 16,
  parameter int SEG_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] program_word,
  input  logic [7:0]  in_byte,
  input  logic        in_end,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        input_taken,
  output logic        stopped,
  output logic [2:0]  fault_code
);

  cmd_t    cmd;
  status_t st;

  umc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  umc_dp #(
    .SEG_COUNT (SEG_COUNT),
    .SEG_WORDS (SEG_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .program_word (program_word),
    .in_byte      (in_byte),
    .in_end       (in_end),
    .res_stall    (res_stall),
    .st           (st),
    .res_valid    (res_valid),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .input_taken  (input_taken),
    .stopped      (stopped),
    .fault_code   (fault_code)
  );

endmodule

// ----- bench/segmented_um_core_top_tb.sv -----
module segmented_um_core_top_tb
  import umc_pkg::*;
();

  localparam int SEGS = 16;
  localparam int WORDS = 4096;
  localparam logic REQ_EXEC = ~REQ_APPEND;
  localparam int ITEM_GOAL = 1750;

  typedef struct packed {
    logic       ov;
    logic [7:0] ob;
    logic       taken;
    logic       stp;
    logic [2:0] fc;
  } um_result_t;

  typedef struct packed {
    logic        req;
    logic [31:0] word;
    logic [7:0]  ib;
    logic        ie;
    logic        typed;
    um_result_t  res;
  } stim_row_t;

  localparam um_result_t R_IDLE = '{1'b0, 8'h00, 1'b0, 1'b0, FLT_NONE};

  localparam int N_ROWS = 22;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{REQ_APPEND, {OP_IMM, 3'd1, 25'h41}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_APPEND, {OP_OUT, 19'h7FFFF, 3'd0, 3'd0, 3'd1}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h41, 1'b0, 1'b0, FLT_NONE}},
    '{REQ_APPEND, {OP_IMM, 3'd2, 25'h1FF_FFFF}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_APPEND, {OP_IMM, 3'd7, 25'h0}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_APPEND, {OP_ADD, 19'h0, 3'd3, 3'd2, 3'd2}, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_APPEND, {OP_MUL, 19'h0, 3'd4, 3'd3, 3'd2}, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_APPEND, {OP_NAND, 19'h0, 3'd5, 3'd4, 3'd4}, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_APPEND, {OP_IN, 19'h0, 3'd0, 3'd0, 3'd6}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'hFF, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, FLT_NONE}},
    '{REQ_APPEND, {OP_IN, 19'h0, 3'd0, 3'd0, 3'd6}, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h5A, 1'b1, 1'b1, R_IDLE},
    '{REQ_APPEND, {OP_DIV, 19'h0, 3'd0, 3'd6, 3'd1}, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_APPEND, {OP_CMOV, 19'h0, 3'd7, 3'd5, 3'd1}, 8'h00, 1'b0, 1'b0, R_IDLE},
    '{REQ_EXEC, 32'h0, 8'h00, 1'b0, 1'b0, R_IDLE}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = REQ_APPEND;
  logic [31:0] program_word = '0;
  logic [7:0]  in_byte = '0;
  logic        in_end = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        input_taken;
  logic        stopped;
  logic [2:0]  fault_code;

  segmented_um_core_top dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .program_word, .in_byte, .in_end,
    .res_valid, .res_stall, .out_valid, .out_byte, .input_taken, .stopped, .fault_code
  );

  // machine state mirror
  logic [31:0] um_regs [8];
  logic [31:0] um_pc;
  logic [31:0] seg_mem [SEGS*WORDS];
  int unsigned seg_len [SEGS];
  bit          seg_on [SEGS];
  int unsigned free_ids [SEGS];
  int unsigned free_hd, free_tl, free_cnt, fresh_id;
  bit          um_stop;
  logic [2:0]  um_cause;

  um_result_t  expected_q [$];
  int          errors = 0;
  int          sent = 0;
  int          burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void machine_reset();
    for (int i = 0; i < 8; i++) um_regs[i] = '0;
    for (int i = 0; i < SEGS; i++) begin
      seg_len[i] = 0;
      seg_on[i] = 1'b0;
      free_ids[i] = 0;
    end
    seg_on[0] = 1'b1;
    um_pc = '0;
    free_hd = 0;
    free_tl = 0;
    free_cnt = 0;
    fresh_id = 1;
    um_stop = 1'b0;
    um_cause = FLT_NONE;
  endfunction

  function automatic void trap(logic [2:0] cause);
    um_stop = 1'b1;
    um_cause = cause;
  endfunction

  function automatic bit seg_live(logic [31:0] s);
    return s < SEGS && seg_on[s[3:0]];
  endfunction

  function automatic um_result_t um_advance(logic req, logic [31:0] word, logic [7:0] ib,
                                            logic ie);
    um_result_t  r;
    logic [31:0] w, va, vb, vc;
    logic [3:0]  op;
    int unsigned a, b, c, id;
    bit          ok;
    r = '0;
    if (req == REQ_APPEND) begin
      if (seg_len[0] < WORDS) begin
        seg_mem[seg_len[0]] = word;
        seg_len[0]++;
      end
    end else if (!um_stop) begin
      if (um_pc >= seg_len[0]) begin
        trap(FLT_PC_END);
      end else begin
        w = seg_mem[um_pc];
        um_pc++;
        op = w[31:28];
        a = 32'(w[8:6]);
        b = 32'(w[5:3]);
        c = 32'(w[2:0]);
        va = um_regs[a];
        vb = um_regs[b];
        vc = um_regs[c];
        case (op)
          OP_CMOV: if (vc != 0) um_regs[a] = vb;
          OP_LOAD: begin
            if (!seg_live(vb) || vc >= seg_len[vb[3:0]]) trap(FLT_SEGMENT);
            else um_regs[a] = seg_mem[vb[3:0]*WORDS + vc];
          end
          OP_STORE: begin
            if (!seg_live(va) || vb >= seg_len[va[3:0]]) trap(FLT_SEGMENT);
            else seg_mem[va[3:0]*WORDS + vb] = vc;
          end
          OP_ADD: um_regs[a] = vb + vc;
          OP_MUL: um_regs[a] = vb * vc;
          OP_DIV: begin
            if (vc == 0) trap(FLT_DIVZERO);
            else um_regs[a] = vb / vc;
          end
          OP_NAND: um_regs[a] = ~(vb & vc);
          OP_HALT: trap(FLT_NONE);
          OP_MAP: begin
            ok = 1'b1;
            if (vc > WORDS) begin
              trap(FLT_MAP);
              ok = 1'b0;
            end else if (free_cnt != 0) begin
              id = free_ids[free_hd];
              free_hd = (free_hd + 1) % SEGS;
              free_cnt--;
            end else if (fresh_id < SEGS) begin
              id = fresh_id++;
            end else begin
              trap(FLT_MAP);
              ok = 1'b0;
            end
            if (ok) begin
              for (int i = 0; i < vc; i++) seg_mem[id*WORDS + i] = '0;
              seg_len[id] = vc;
              seg_on[id] = 1'b1;
              um_regs[b] = id;
            end
          end
          OP_UNMAP: begin
            if (vc == 0 || !seg_live(vc) || free_cnt >= SEGS) begin
              trap(FLT_UNMAP);
            end else begin
              seg_on[vc[3:0]] = 1'b0;
              seg_len[vc[3:0]] = 0;
              free_ids[free_tl] = 32'(vc[3:0]);
              free_tl = (free_tl + 1) % SEGS;
              free_cnt++;
            end
          end
          OP_OUT: begin
            if (vc > OUT_MAX) begin
              trap(FLT_OUTPUT);
            end else begin
              r.ov = 1'b1;
              r.ob = vc[7:0];
            end
          end
          OP_IN: begin
            if (ie) begin
              um_regs[c] = '1;
            end else begin
              um_regs[c] = {24'h0, ib};
              r.taken = 1'b1;
            end
          end
          OP_LOADPROG: begin
            if (vb != 0 && !seg_live(vb)) begin
              trap(FLT_SEGMENT);
            end else begin
              if (vb != 0) begin
                for (int i = 0; i < seg_len[vb[3:0]]; i++)
                  seg_mem[i] = seg_mem[vb[3:0]*WORDS + i];
                seg_len[0] = seg_len[vb[3:0]];
              end
              um_pc = vc;
            end
          end
          OP_IMM: um_regs[w[27:25]] = {7'h0, w[24:0]};
          default: trap(FLT_OPCODE);
        endcase
      end
    end
    r.stp = um_stop;
    r.fc = um_cause;
    return r;
  endfunction

  task automatic send(input logic req, input logic [31:0] word, input logic [7:0] ib,
                      input logic ie, input bit typed = 1'b0, input um_result_t given = '0);
    um_result_t pred;
    pred = um_advance(req, word, ib, ie);
    expected_q.push_back(typed ? given : pred);
    in_valid <= 1'b1;
    opcode <= req;
    program_word <= word;
    in_byte <= ib;
    in_end <= ie;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic issue_instr(logic [31:0] w);
    send(REQ_APPEND, w, 8'($urandom), 1'($urandom));
    send(REQ_EXEC, $urandom, 8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  function automatic logic [31:0] enc(logic [3:0] op, int a, int b, int c);
    return {op, 19'($urandom), 3'(a), 3'(b), 3'(c)};
  endfunction

  function automatic logic [31:0] imm(int a, logic [31:0] v);
    return {OP_IMM, 3'(a), v[24:0]};
  endfunction

  function automatic int pick_seg(bit skip0, bit need_words);
    int cand [$];
    for (int i = 0; i < SEGS; i++)
      if (seg_on[i] && !(skip0 && i == 0) && !(need_words && seg_len[i] == 0))
        cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic map_or_unmap(bit want_map, int unsigned size);
    int s, b, c;
    b = $urandom_range(0, 7);
    c = (b + $urandom_range(1, 7)) % 8;
    s = pick_seg(1'b1, 1'b0);
    if (want_map && free_cnt == 0 && fresh_id >= SEGS) want_map = 1'b0;
    if (!want_map && s < 0) want_map = 1'b1;
    if (want_map) begin
      issue_instr(imm(c, size));
      issue_instr(enc(OP_MAP, $urandom_range(0, 7), b, c));
    end else begin
      issue_instr(imm(c, s));
      issue_instr(enc(OP_UNMAP, $urandom_range(0, 7), b, c));
    end
  endtask

  task automatic jump_ahead(int s);
    int b, c;
    int unsigned base;
    b = $urandom_range(0, 7);
    c = (b + $urandom_range(1, 7)) % 8;
    base = seg_len[0];
    issue_instr(imm(b, s));
    issue_instr(imm(c, (s == 0) ? base + 3 : seg_len[s]));
    issue_instr(enc(OP_LOADPROG, $urandom_range(0, 7), b, c));
  endtask

  task automatic random_instr();
    int a, b, c, s;
    a = $urandom_range(0, 7);
    b = $urandom_range(0, 7);
    c = (b + $urandom_range(1, 7)) % 8;
    case ($urandom_range(0, 15))
      0: issue_instr(enc(OP_CMOV, a, b, c));
      1, 2: begin
        s = pick_seg(1'b0, 1'b1);
        issue_instr(imm(b, s));
        issue_instr(imm(c, $urandom_range(0, seg_len[s] - 1)));
        issue_instr(enc(OP_LOAD, a, b, c));
      end
      3: begin
        s = pick_seg(1'b0, 1'b1);
        issue_instr(imm(b, s));
        issue_instr(imm(c, $urandom_range(0, seg_len[s] - 1)));
        issue_instr(enc(OP_STORE, b, c, $urandom_range(0, 7)));
      end
      4: issue_instr(enc(OP_ADD, a, b, c));
      5: issue_instr(enc(OP_MUL, a, b, c));
      6: begin
        if (um_regs[c] == 0) issue_instr(imm(c, $urandom_range(1, 25'h1FF_FFFF)));
        issue_instr(enc(OP_DIV, a, b, c));
      end
      7: issue_instr(enc(OP_NAND, a, b, c));
      8: map_or_unmap(1'b1, $urandom_range(0, 12));
      9: map_or_unmap(1'b0, 0);
      10: begin
        issue_instr(imm(c, $urandom_range(0, 255)));
        issue_instr(enc(OP_OUT, a, b, c));
      end
      11: issue_instr(enc(OP_IN, a, b, c));
      12: begin
        s = pick_seg(1'b1, 1'b0);
        jump_ahead(($urandom_range(0, 1) && s > 0) ? s : 0);
      end
      default: issue_instr(imm(a, $urandom));
    endcase
  endtask

  task automatic stop_machine();
    int b, c;
    b = $urandom_range(0, 7);
    c = (b + $urandom_range(1, 7)) % 8;
    case ($urandom_range(0, 8))
      0: issue_instr(enc(OP_HALT, 0, b, c));
      1: begin
        issue_instr(imm(c, 0));
        issue_instr(enc(OP_DIV, 0, b, c));
      end
      2: begin
        issue_instr(imm(b, $urandom_range(SEGS, 25'h1FF_FFFF)));
        issue_instr(enc(OP_LOAD, 0, b, c));
      end
      3: issue_instr({4'(14 + $urandom_range(0, 1)), 28'($urandom)});
      4: begin
        issue_instr(imm(c, $urandom_range(256, 25'h1FF_FFFF)));
        issue_instr(enc(OP_OUT, 0, b, c));
      end
      5: map_or_unmap(1'b1, $urandom_range(WORDS + 1, WORDS + 100));
      6: begin
        issue_instr(imm(c, 0));
        issue_instr(enc(OP_UNMAP, 0, b, c));
      end
      7: send(REQ_EXEC, $urandom, 8'($urandom), 1'($urandom));
      default: begin
        // fill segment zero to capacity, then run off its end
        if (free_cnt == 0 && fresh_id >= SEGS) map_or_unmap(1'b0, 0);
        issue_instr(imm(c, WORDS));
        issue_instr(enc(OP_MAP, 0, 5, c));
        jump_ahead(um_regs[5]);
        send(REQ_APPEND, $urandom, 8'($urandom), 1'($urandom));
        send(REQ_EXEC, $urandom, 8'($urandom), 1'($urandom));
      end
    endcase
    repeat (6) send(1'($urandom_range(0, 1)), $urandom, 8'($urandom), 1'($urandom));
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    um_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_valid !== want.ov) report("out_valid", 32'(out_valid), 32'(want.ov));
        if (out_byte !== want.ob) report("out_byte", 32'(out_byte), 32'(want.ob));
        if (input_taken !== want.taken)
          report("input_taken", 32'(input_taken), 32'(want.taken));
        if (stopped !== want.stp) report("stopped", 32'(stopped), 32'(want.stp));
        if (fault_code !== want.fc) report("fault_code", 32'(fault_code), 32'(want.fc));
      end
    end
  end

  int stall_pct = 0;
  int stall_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 90;
          default: stall_pct = $urandom_range(10, 60);
        endcase
      end
      stall_hold--;
      res_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    machine_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_ROWS; i++)
      send(DIRECTED[i].req, DIRECTED[i].word, DIRECTED[i].ib, DIRECTED[i].ie,
           DIRECTED[i].typed, DIRECTED[i].res);
    while (sent < ITEM_GOAL - 20) begin
      random_instr();
      if (!paused && sent > ITEM_GOAL / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    stop_machine();
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
